@@ hdl/mct_pkg.sv @@
`timescale 1ns / 1ps

package mct_pkg;

   // Fixed field widths of the transaction payloads and registers.
   localparam int PMT_ID_W    = 6;
   localparam int REQUIRED_W  = 6;
   localparam int LEN_W       = 24;
   localparam int DISTINCT_W  = 6;
   localparam int TRIG_CNT_W  = 32;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 24;

   localparam logic [LEN_W-1:0]      WINDOW_LENGTH_RESET = 24'd320;
   localparam logic [REQUIRED_W-1:0] REQUIRED_PMTS_RESET = 6'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_LENGTH = 1'b0,
      CSR_REQUIRED_PMTS = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_UPDATE
   } state_type;

   // Request from the sequencer to the tube tracker.
   typedef struct packed {
      logic                commit;
      logic [PMT_ID_W-1:0] pmt_id;
   } update_type;

   // Outcome of one hit as seen by the tube tracker.
   typedef struct packed {
      logic [DISTINCT_W-1:0] distinct_pmts;
      logic                  fired;
      logic [TRIG_CNT_W-1:0] trigger_count;
   } outcome_type;

endpackage

@@ hdl/mct_channels.sv @@
`timescale 1ns / 1ps

interface mct_req_if #(
   parameter int TIME_BITS = 40
) ();
   logic                          valid;
   logic                          ready;
   logic [TIME_BITS-1:0]          hit_time;
   logic [mct_pkg::PMT_ID_W-1:0]  pmt_id;

   modport source (output valid, hit_time, pmt_id, input ready);
   modport sink   (input valid, hit_time, pmt_id, output ready);
endinterface

interface mct_rsp_if #(
   parameter int TIME_BITS = 40
) ();
   logic                            valid;
   logic                            ready;
   logic [TIME_BITS-1:0]            window_index;
   logic [mct_pkg::DISTINCT_W-1:0]  distinct_pmts;
   logic                            fired;
   logic [mct_pkg::TRIG_CNT_W-1:0]  trigger_count;

   modport source (output valid, window_index, distinct_pmts, fired, trigger_count,
                   input ready);
   modport sink   (input valid, window_index, distinct_pmts, fired, trigger_count,
                   output ready);
endinterface

@@ hdl/mct_divider.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module mct_divider #(
   parameter int TIME_BITS = 40
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [TIME_BITS-1:0]          dividend,
   input  logic [mct_pkg::LEN_W-1:0]     divisor,
   output logic                          done,
   output logic [TIME_BITS-1:0]          quotient
);

   localparam int CNT_W = $clog2(TIME_BITS + 1);

   logic                          busy_ff,  busy_in;
   logic                          done_ff,  done_in;
   logic [CNT_W-1:0]              cnt_ff,   cnt_in;
   logic [TIME_BITS-1:0]          quo_ff,   quo_in;
   logic [mct_pkg::LEN_W-1:0]     rem_ff,   rem_in;
   logic [mct_pkg::LEN_W-1:0]     div_ff,   div_in;
   logic [mct_pkg::LEN_W:0]       trial;
   logic [mct_pkg::LEN_W:0]       diff;
   logic                          ge;

   assign trial = {rem_ff, quo_ff[TIME_BITS-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign ge    = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(TIME_BITS);
         quo_in  = dividend;
         rem_in  = '0;
         // A zero length divides by one instead.
         div_in  = (divisor == '0) ? mct_pkg::LEN_W'(1) : divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[TIME_BITS-2:0], ge};
         rem_in = ge ? diff[mct_pkg::LEN_W-1:0] : trial[mct_pkg::LEN_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hdl/mct_tube_tracker.sv @@
`timescale 1ns / 1ps

// Holds the window state, the tube bitmap and the fire counter.
module mct_tube_tracker #(
   parameter int NUM_TUBES = 36,
   parameter int TIME_BITS = 40
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mct_pkg::update_type                update,
   input  logic [TIME_BITS-1:0]               window_index,
   input  logic [mct_pkg::REQUIRED_W-1:0]     required_pmts,
   output mct_pkg::outcome_type               outcome
);

   localparam int IDX_W = $clog2(NUM_TUBES);
   localparam int CW    = $clog2(NUM_TUBES + 1);
   localparam int CMP_W = mct_pkg::PMT_ID_W + 1;

   logic                               valid_ff,   valid_in;
   logic [TIME_BITS-1:0]               current_ff, current_in;
   logic [NUM_TUBES-1:0]               seen_ff,    seen_in;
   logic [CW-1:0]                      count_ff,   count_in;
   logic [mct_pkg::TRIG_CNT_W-1:0]     total_ff,   total_in;

   logic                               new_window;
   logic [NUM_TUBES-1:0]               base_seen;
   logic [CW-1:0]                      base_count;
   logic                               in_range;
   logic [IDX_W-1:0]                   tube_idx;
   logic                               is_new;
   logic                               fire;
   logic [CW+mct_pkg::DISTINCT_W-1:0]  count_ext;

   assign new_window = !valid_ff || (window_index != current_ff);
   assign base_seen  = new_window ? '0 : seen_ff;
   assign base_count = new_window ? '0 : count_ff;
   assign in_range   = {1'b0, update.pmt_id} < CMP_W'(NUM_TUBES);
   assign tube_idx   = update.pmt_id[IDX_W-1:0];
   assign is_new     = in_range && !base_seen[tube_idx];

   always_comb begin
      seen_in  = base_seen;
      count_in = base_count;
      fire     = 1'b0;
      total_in = total_ff;
      if (is_new) begin
         seen_in[tube_idx] = 1'b1;
         count_in          = base_count + CW'(1);
         if (CMP_W'(count_in) == {1'b0, required_pmts}) begin
            fire = 1'b1;
            if (!(&total_ff)) begin
               total_in = total_ff + mct_pkg::TRIG_CNT_W'(1);
            end
         end
      end
   end

   assign valid_in   = 1'b1;
   assign current_in = window_index;
   assign count_ext  = {{mct_pkg::DISTINCT_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         current_ff <= '0;
         seen_ff    <= '0;
         count_ff   <= '0;
         total_ff   <= '0;
      end else if (update.commit) begin
         valid_ff   <= valid_in;
         current_ff <= current_in;
         seen_ff    <= seen_in;
         count_ff   <= count_in;
         total_ff   <= total_in;
      end
   end

   assign outcome.distinct_pmts = count_ext[mct_pkg::DISTINCT_W-1:0];
   assign outcome.fired         = fire;
   assign outcome.trigger_count = total_in;

endmodule

@@ hdl/multiplicity_coincidence_trigger_core.sv @@
`timescale 1ns / 1ps

// Multiplicity coincidence trigger. Each hit transaction carries an arrival time
// and a tube number; the block divides the time by window_length to find the
// window number, clears its tube bitmap whenever that number changes, and marks
// the hit as fired when it is the one that first brings the count of distinct
// tubes in its window up to required_pmts. One result transaction leaves for
// every hit. Each hit passes from acceptance through the bit-serial restoring
// divider, which produces one quotient bit per cycle, to the sequencer, which
// picks up the divider's done flag, and then updates the bitmap and the
// counters and registers the result. The block takes one hit at a time, but it
// accepts the next hit while the previous result is still waiting in the output
// register, though not before that result is registered; a result that is held
// back in the output register delays the update of the following hit for as
// long as it waits. A window length of zero is treated as one, tube numbers at
// or above NUM_TUBES are not recorded and cannot fire, and the trigger count
// saturates at its maximum. The configuration registers should only be written
// while no hit is in flight.
module multiplicity_coincidence_trigger_core #(
   parameter int NUM_TUBES = 36,
   parameter int TIME_BITS = 40
) (
   input  logic                                clock,
   input  logic                                reset,
   mct_req_if.sink                             req_bus,
   mct_rsp_if.source                           rsp_bus,
   input  logic                                csr_write_en,
   input  logic [mct_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mct_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   mct_pkg::state_type                 state_ff, state_in;

   logic [mct_pkg::LEN_W-1:0]          window_length_ff, window_length_in;
   logic [mct_pkg::REQUIRED_W-1:0]     required_ff,      required_in;

   logic [mct_pkg::PMT_ID_W-1:0]       pmt_ff,           pmt_in;

   logic                               rsp_valid_ff,     rsp_valid_in;
   logic [TIME_BITS-1:0]               window_ff,        window_in;
   mct_pkg::outcome_type               outcome_ff,       outcome_in;

   logic                               accept;
   logic                               out_free;
   logic                               div_done;
   logic [TIME_BITS-1:0]               quotient;
   mct_pkg::update_type                update;
   mct_pkg::outcome_type               outcome;

   // Configuration registers; the index is decoded against the register map.
   always_comb begin
      window_length_in = window_length_ff;
      required_in      = required_ff;
      if (csr_write_en) begin
         unique case (mct_pkg::csr_index_type'(csr_index))
            mct_pkg::CSR_WINDOW_LENGTH: window_length_in = csr_wdata;
            mct_pkg::CSR_REQUIRED_PMTS: required_in      = csr_wdata[mct_pkg::REQUIRED_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= mct_pkg::WINDOW_LENGTH_RESET;
         required_ff      <= mct_pkg::REQUIRED_PMTS_RESET;
      end else begin
         window_length_ff <= window_length_in;
         required_ff      <= required_in;
      end
   end

   // The output register is free when empty or when its transaction leaves now.
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign accept   = req_bus.valid && req_bus.ready;

   // Sequencer: take a hit, divide its time, then commit once the output is free.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mct_pkg::ST_IDLE:   if (req_bus.valid) state_in = mct_pkg::ST_DIVIDE;
         mct_pkg::ST_DIVIDE: if (div_done)      state_in = mct_pkg::ST_UPDATE;
         mct_pkg::ST_UPDATE: if (out_free)      state_in = mct_pkg::ST_IDLE;
         default:                               state_in = mct_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready = 1'b0;
      update.commit = 1'b0;
      update.pmt_id = pmt_ff;
      unique case (state_ff)
         mct_pkg::ST_IDLE:   req_bus.ready = 1'b1;
         mct_pkg::ST_DIVIDE: ;
         mct_pkg::ST_UPDATE: update.commit = out_free;
         default: ;
      endcase
   end

   assign pmt_in = accept ? req_bus.pmt_id : pmt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mct_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      pmt_ff <= pmt_in;
   end

   mct_divider #(
      .TIME_BITS (TIME_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (req_bus.hit_time),
      .divisor  (window_length_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   mct_tube_tracker #(
      .NUM_TUBES (NUM_TUBES),
      .TIME_BITS (TIME_BITS)
   ) u_tracker (
      .clock         (clock),
      .reset         (reset),
      .update        (update),
      .window_index  (quotient),
      .required_pmts (required_ff),
      .outcome       (outcome)
   );

   // Output register for the result transaction.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      window_in    = window_ff;
      outcome_in   = outcome_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (update.commit) begin
         rsp_valid_in = 1'b1;
         window_in    = quotient;
         outcome_in   = outcome;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      window_ff  <= window_in;
      outcome_ff <= outcome_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.window_index  = window_ff;
   assign rsp_bus.distinct_pmts = outcome_ff.distinct_pmts;
   assign rsp_bus.fired         = outcome_ff.fired;
   assign rsp_bus.trigger_count = outcome_ff.trigger_count;

endmodule
